// ===== rtl/z80ocd_pkg.sv =====
// z80 opcode class decoder: shared types, table selector codes, class tables
// and the single-byte classification function
// no dependencies
package z80ocd_pkg;

  localparam int unsigned OPCODE_W = 8;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned CLASS_W  = 8;
  localparam int unsigned REG_W    = 3;
  localparam int unsigned OUT_TDATA_W = 16;

  // opcode table selector carried with each beat
  typedef enum logic [ACTION_W-1:0] {
    TBL_MAIN = 2'd0,
    TBL_CB   = 2'd1,
    TBL_ED   = 2'd2
  } table_t;

  localparam logic [REG_W-1:0]   HL_REG    = 3'd6;
  localparam logic [CLASS_W-1:0] CLASS_BAD = 8'd0;

  // ed opcodes singled out by full byte compare
  localparam logic [OPCODE_W-1:0] ED_NEG  = 8'h44;
  localparam logic [OPCODE_W-1:0] ED_RETN = 8'h45;
  localparam logic [OPCODE_W-1:0] ED_RETI = 8'h4D;

  // register alu: (hl) form class per field, the r form is one above
  // field order add adc sub sbc and xor or cp
  localparam logic [CLASS_W-1:0] ALU_R_BASE [8] = '{
    8'd28, 8'd30, 8'd32, 8'd34, 8'd36, 8'd40, 8'd38, 8'd42
  };

  // cb rotate/shift: (hl) form per field, sll slot unused
  localparam logic [CLASS_W-1:0] CB_ROT_BASE [8] = '{
    8'd82, 8'd84, 8'd86, 8'd88, 8'd90, 8'd92, 8'd0, 8'd94
  };

  typedef struct packed {
    logic [CLASS_W-1:0] op_class;
    logic               regs_valid;
  } dec_t;

  function automatic dec_t decode_op(input logic [ACTION_W-1:0] action,
                                     input logic [OPCODE_W-1:0] op);
    dec_t       d;
    logic [1:0] x;
    logic [2:0] y;
    logic [2:0] z;
    logic [1:0] p;
    logic       q;
    logic       hl_n;
    x    = op[7:6];
    y    = op[5:3];
    z    = op[2:0];
    p    = op[5:4];
    q    = op[3];
    hl_n = (z != HL_REG);
    d.op_class   = CLASS_BAD;
    d.regs_valid = 1'b0;
    case (action)
      TBL_MAIN: begin
        case (x)
          2'd3: begin
            case (z)
              3'd0:    d.op_class = 8'd1;
              3'd1:    d.op_class = q ? 8'd2 + {6'd0, p} : 8'd6;
              3'd2:    d.op_class = 8'd7;
              3'd3:    d.op_class = q ? 8'd8 + {6'd0, p} : 8'd12;
              3'd4:    d.op_class = 8'd13;
              3'd5:    d.op_class = q ? 8'd14 + {6'd0, p} : 8'd18;
              3'd6:    d.op_class = 8'd19 + {5'd0, y};
              default: d.op_class = 8'd27;
            endcase
          end
          2'd2: d.op_class = ALU_R_BASE[y] + {7'd0, hl_n};
          2'd1: begin
            if (y == HL_REG) begin
              d.op_class = hl_n ? 8'd45 : 8'd44;
            end else if (!hl_n) begin
              d.op_class = 8'd46;
            end else begin
              d.op_class   = 8'd47;
              d.regs_valid = 1'b1;
            end
          end
          default: begin
            case (z)
              3'd0:    d.op_class = 8'd48 + {5'd0, y};
              3'd1:    d.op_class = q ? 8'd56 : 8'd57;
              3'd2:    d.op_class = (q ? 8'd58 : 8'd62) + {6'd0, p};
              3'd3:    d.op_class = q ? 8'd66 : 8'd67;
              3'd4:    d.op_class = (y == HL_REG) ? 8'd68 : 8'd69;
              3'd5:    d.op_class = (y == HL_REG) ? 8'd70 : 8'd71;
              3'd6:    d.op_class = (y == HL_REG) ? 8'd72 : 8'd73;
              default: d.op_class = 8'd74 + {5'd0, y};
            endcase
          end
        endcase
      end
      TBL_CB: begin
        case (x)
          2'd0:    d.op_class = (y == 3'd6) ? CLASS_BAD
                                            : CB_ROT_BASE[y] + {7'd0, hl_n};
          2'd1:    d.op_class = 8'd96 + {7'd0, hl_n};
          2'd2:    d.op_class = 8'd98 + {7'd0, hl_n};
          default: d.op_class = 8'd100 + {7'd0, hl_n};
        endcase
      end
      TBL_ED: begin
        if (x == 2'd1) begin
          case (z)
            3'd0: d.op_class = 8'd102;
            // out (c),0 is undocumented
            3'd1: d.op_class = (y == HL_REG) ? CLASS_BAD : 8'd103;
            3'd2: d.op_class = q ? 8'd104 : 8'd105;
            3'd3: d.op_class = q ? 8'd106 : 8'd107;
            3'd4: d.op_class = (op == ED_NEG) ? 8'd108 : CLASS_BAD;
            3'd5: begin
              if (op == ED_RETN)      d.op_class = 8'd109;
              else if (op == ED_RETI) d.op_class = 8'd110;
              else                    d.op_class = CLASS_BAD;
            end
            // only im 0, im 1, im 2
            3'd6: d.op_class = (y[2] || y == 3'd1) ? CLASS_BAD : 8'd111;
            default: d.op_class = (y[2] && y[1]) ? CLASS_BAD
                                                 : 8'd112 + {5'd0, y};
          endcase
        end else if (op[7:5] == 3'd5 && !z[2]) begin
          // block transfer group 101xx0yy
          d.op_class = 8'd118 + {4'd0, z[1:0], y[1:0]};
        end
      end
      default: d.op_class = CLASS_BAD;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/z80_opcode_class_decoder_top.sv =====
// z80 opcode class decoder, stream top level
// pipeline: the input beat is held in the input register, then its result in the result register
// throughput: one beat per cycle, back to back, stalls only on out_tready low
// reset: synchronous active-low rst_n clears both valid flags, no other state
// depends on z80ocd_pkg
module z80_opcode_class_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] opcode
  input  logic [1:0]  in_tuser,   // [1:0] action (opcode table)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] op_class, [10:8] source_reg, [13:11] dest_reg
  output logic [0:0]  out_tuser   // [0] regs_valid
);

  logic                                 s1_valid_r;
  logic [z80ocd_pkg::ACTION_W-1:0]      s1_action_r;
  logic [z80ocd_pkg::OPCODE_W-1:0]      s1_opcode_r;
  logic                                 s2_valid_r;
  logic [z80ocd_pkg::CLASS_W-1:0]       s2_class_r;
  logic                                 s2_regs_valid_r;
  logic [z80ocd_pkg::REG_W-1:0]         s2_src_r;
  logic [z80ocd_pkg::REG_W-1:0]         s2_dst_r;

  logic                                 s2_ready;
  logic                                 s1_ready;
  z80ocd_pkg::dec_t                     dec;
  logic [z80ocd_pkg::REG_W-1:0]         src_nxt;
  logic [z80ocd_pkg::REG_W-1:0]         dst_nxt;

  assign s2_ready  = !s2_valid_r || out_tready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;

  always_comb begin
    dec     = z80ocd_pkg::decode_op(s1_action_r, s1_opcode_r);
    // register fields only mean something for ld r,r'
    src_nxt = dec.regs_valid ? s1_opcode_r[2:0] : '0;
    dst_nxt = dec.regs_valid ? s1_opcode_r[5:3] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_tvalid) begin
      s1_action_r <= in_tuser;
      s1_opcode_r <= in_tdata;
    end
    if (s2_ready && s1_valid_r) begin
      s2_class_r      <= dec.op_class;
      s2_regs_valid_r <= dec.regs_valid;
      s2_src_r        <= src_nxt;
      s2_dst_r        <= dst_nxt;
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tdata  = {2'b00, s2_dst_r, s2_src_r, s2_class_r};
  assign out_tuser  = s2_regs_valid_r;

endmodule
